/* hw/rtl/pfi_pkg.sv */
// Shared types, constants and helpers of the palette fade interpolator.
`default_nettype none

package pfi_pkg;

  // Store geometry and field widths
  localparam int PaletteEntries = 256;
  localparam int ReqW           = 2;
  localparam int IndexW         = 8;
  localparam int ChanW          = 8;
  localparam int FrameW         = 8;
  localparam int Color6W        = 6;

  // Queue between front and back
  localparam int QueueDepth  = 2;
  localparam int QueueLevelW = $clog2(QueueDepth + 1);

  // Divider: quotient bits, bits resolved per cycle, steps per division
  localparam int QuotW          = 8;
  localparam int DivBitsPerStep = 4;
  localparam int DivSteps       = QuotW / DivBitsPerStep;
  localparam int DivCntW        = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  // Configuration port
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  typedef enum logic [ReqW-1:0] {
    REQ_WR_START  = 2'd0,
    REQ_WR_TARGET = 2'd1,
    REQ_RD_FADED  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    REG_STEP_COUNT  = 3'd0,
    REG_FIRST_INDEX = 3'd1,
    REG_LAST_INDEX  = 3'd2,
    REG_FADE_MODE   = 3'd3,
    REG_COLOR_RED   = 3'd4,
    REG_COLOR_GREEN = 3'd5,
    REG_COLOR_BLUE  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_e;

  typedef logic [ChanW-1:0] chan_t;

  // Red in the low byte, blue in the high byte
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } rgb_t;

  typedef struct packed {
    logic [FrameW-1:0]  step_count;
    logic [IndexW-1:0]  first_index;
    logic [IndexW-1:0]  last_index;
    logic               fade_mode;
    logic [Color6W-1:0] color_red;
    logic [Color6W-1:0] color_green;
    logic [Color6W-1:0] color_blue;
  } cfg_t;

  // One classified read waiting for the back end
  typedef struct packed {
    rgb_t              start;
    rgb_t              target;
    logic [FrameW-1:0] frame;
    logic              final_frame;
    logic              interp;
  } work_t;

  // Widen a 6-bit channel to 8 bits: c*255/63 equals 4*c + c/21
  function automatic chan_t widen6(logic [Color6W-1:0] c);
    logic [1:0] extra;
    if (c >= 6'd63) begin
      extra = 2'd3;
    end else if (c >= 6'd42) begin
      extra = 2'd2;
    end else if (c >= 6'd21) begin
      extra = 2'd1;
    end else begin
      extra = 2'd0;
    end
    return {c, 2'b00} + chan_t'(extra);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfi_if.sv */
// Request and response channel interfaces of the palette fade interpolator.
`default_nettype none

interface pfi_req_if;
  import pfi_pkg::*;

  logic              valid;
  logic              ready;
  logic [ReqW-1:0]   req_type;
  logic [IndexW-1:0] entry_index;
  logic [ChanW-1:0]  in_red;
  logic [ChanW-1:0]  in_green;
  logic [ChanW-1:0]  in_blue;
  logic [FrameW-1:0] frame_number;

  modport source (
    output valid, req_type, entry_index, in_red, in_green, in_blue, frame_number,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, in_red, in_green, in_blue, frame_number,
    output ready
  );
endinterface

interface pfi_rsp_if;
  import pfi_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;

  modport source (
    output valid, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/pfi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfi_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/pfi_front.sv */
// Front end: accepts request words, writes the stores, classifies reads.
`default_nettype none

module pfi_front #(
  parameter int PaletteEntries = pfi_pkg::PaletteEntries
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfi_pkg::cfg_t                    cfg_i,
  pfi_req_if.sink                          req_i,
  input  logic [pfi_pkg::QueueLevelW-1:0]  q_level_i,
  output logic                             q_push_o,
  output pfi_pkg::work_t                   q_data_o
);
  import pfi_pkg::*;

  localparam int AddrW = $clog2(PaletteEntries);

  logic               accept;
  logic               present;
  logic [31:0]        idx_ext;
  logic [AddrW-1:0]   addr;
  logic               we_start;
  logic               we_target;
  logic               rd_req;
  logic [QueueLevelW:0] credit;
  logic [3*ChanW-1:0] wdata;
  logic [3*ChanW-1:0] start_rdata;
  logic [3*ChanW-1:0] target_rdata;
  rgb_t               fixed_color;

  logic               pend_q;
  logic               pend_present_q;
  logic [FrameW-1:0]  pend_frame_q;
  logic               pend_final_q;
  logic               pend_interp_q;

  // Hold off when queued plus in-flight reads would overrun the queue
  assign credit       = {1'b0, q_level_i} + (QueueLevelW + 1)'(pend_q);
  assign req_i.ready  = credit < (QueueLevelW + 1)'(QueueDepth);
  assign accept       = req_i.valid && req_i.ready;

  // Entry address and range check against the store depth
  assign idx_ext = 32'(req_i.entry_index);
  assign present = idx_ext < 32'(PaletteEntries);
  assign addr    = idx_ext[AddrW-1:0];
  assign wdata   = {req_i.in_blue, req_i.in_green, req_i.in_red};

  // Decode the request word
  always_comb begin
    we_start  = 1'b0;
    we_target = 1'b0;
    rd_req    = 1'b0;
    if (accept) begin
      unique case (req_e'(req_i.req_type))
        REQ_WR_START:  we_start  = present;
        REQ_WR_TARGET: we_target = present;
        REQ_RD_FADED:  rd_req    = 1'b1;
        default: ;
      endcase
    end
  end

  pfi_ram #(
    .Width (3 * ChanW),
    .Depth (PaletteEntries)
  ) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (we_start),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (rd_req),
    .raddr_i (addr),
    .rdata_o (start_rdata)
  );

  pfi_ram #(
    .Width (3 * ChanW),
    .Depth (PaletteEntries)
  ) u_target_ram (
    .clk_i   (clk_i),
    .we_i    (we_target),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (rd_req),
    .raddr_i (addr),
    .rdata_o (target_rdata)
  );

  // Track a read whose store data arrives next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= rd_req;
    end
  end

  // Classify the read while the stores are looked up
  always_ff @(posedge clk_i) begin
    if (rd_req) begin
      pend_present_q <= present;
      pend_frame_q   <= req_i.frame_number;
      pend_final_q   <= req_i.frame_number >= cfg_i.step_count;
      pend_interp_q  <= (req_i.entry_index >= cfg_i.first_index) &&
                        (req_i.entry_index <= cfg_i.last_index);
    end
  end

  assign fixed_color.red   = widen6(cfg_i.color_red);
  assign fixed_color.green = widen6(cfg_i.color_green);
  assign fixed_color.blue  = widen6(cfg_i.color_blue);

  // Build the queued word: entries past the store read as zero
  always_comb begin
    q_data_o.start       = pend_present_q ? rgb_t'(start_rdata) : '0;
    q_data_o.target      = fixed_color;
    if (cfg_i.fade_mode) begin
      q_data_o.target    = pend_present_q ? rgb_t'(target_rdata) : '0;
    end
    q_data_o.frame       = pend_frame_q;
    q_data_o.final_frame = pend_final_q;
    q_data_o.interp      = pend_interp_q;
  end

  assign q_push_o = pend_q;

endmodule

`default_nettype wire

/* hw/rtl/pfi_queue.sv */
// Short queue of classified reads between the front and back ends.
`default_nettype none

module pfi_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  pfi_pkg::work_t                  data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output pfi_pkg::work_t                  data_o,
  output logic [pfi_pkg::QueueLevelW-1:0] level_o
);
  import pfi_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  work_t                  slot_q [QueueDepth];
  logic [PtrW-1:0]        wptr_q, wptr_d;
  logic [PtrW-1:0]        rptr_q, rptr_d;
  logic [QueueLevelW-1:0] level_q, level_d;

  // Advance pointers and fill level
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    level_d = level_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rptr_q];
  assign valid_o = level_q != '0;
  assign level_o = level_q;

endmodule

`default_nettype wire

/* hw/rtl/pfi_back.sv */
// Back end: interpolates the three channels with a shared-cycle divider.
`default_nettype none

module pfi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfi_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  pfi_pkg::work_t q_data_i,
  output logic           q_pop_o,
  pfi_rsp_if.source      rsp_o
);
  import pfi_pkg::*;

  back_state_e         state_q, state_d;
  logic [DivCntW-1:0]  cnt_q;
  logic                out_valid_q;
  rgb_t                out_q;
  logic                out_free;
  logic                div_en;
  logic                load_out;
  logic                div_last;

  logic [2:0][ChanW-1:0] head_s;
  logic [2:0][ChanW-1:0] head_t;
  logic [2:0]            head_neg;
  logic [2:0][2*ChanW-1:0] head_prod;

  logic [2:0][ChanW-1:0] start_q;
  logic [2:0][ChanW-1:0] target_q;
  logic                  final_q;
  logic                  interp_q;
  logic [2:0]            neg_q;
  logic [2:0][ChanW-1:0] rem_q, rem_d;
  logic [2:0][ChanW-1:0] low_q, low_d;
  logic [2:0][ChanW-1:0] result;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign div_last = cnt_q == DivCntW'(DivSteps - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_DIV;
      BK_DIV:  if (div_last)  state_d = BK_FIN;
      BK_FIN:  if (out_free)  state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o  = 1'b0;
    div_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: q_pop_o  = q_valid_i;
      BK_DIV:  div_en   = 1'b1;
      BK_FIN:  load_out = out_free;
      default: ;
    endcase
  end

  // Magnitude of the channel difference times the frame
  assign head_s = q_data_i.start;
  assign head_t = q_data_i.target;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      head_neg[k]  = head_t[k] < head_s[k];
      head_prod[k] = (2 * ChanW)'(head_neg[k] ? head_s[k] - head_t[k]
                                              : head_t[k] - head_s[k])
                   * (2 * ChanW)'(q_data_i.frame);
    end
  end

  // Restoring division by the step count, several quotient bits per cycle
  always_comb begin
    logic [ChanW:0]   r9;
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] low;
    logic             ge;
    for (int k = 0; k < 3; k++) begin
      rem = rem_q[k];
      low = low_q[k];
      for (int j = 0; j < DivBitsPerStep; j++) begin
        r9  = {rem, low[ChanW-1]};
        ge  = r9 >= {1'b0, cfg_i.step_count};
        rem = ge ? ChanW'(r9 - {1'b0, cfg_i.step_count}) : r9[ChanW-1:0];
        low = {low[ChanW-2:0], ge};
      end
      rem_d[k] = rem;
      low_d[k] = low;
    end
  end

  // Apply the signed quotient and pick start, blend or target
  always_comb begin
    logic [ChanW-1:0] part;
    for (int k = 0; k < 3; k++) begin
      part = neg_q[k] ? ChanW'(0) - low_q[k] : low_q[k];
      if (final_q) begin
        result[k] = target_q[k];
      end else if (interp_q) begin
        result[k] = start_q[k] + part;
      end else begin
        result[k] = start_q[k];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        cnt_q <= '0;
      end else if (div_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the popped word, then advance the divider
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      start_q  <= head_s;
      target_q <= head_t;
      final_q  <= q_data_i.final_frame;
      interp_q <= q_data_i.interp;
      neg_q    <= head_neg;
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= head_prod[k][2*ChanW-1:ChanW];
        low_q[k] <= head_prod[k][ChanW-1:0];
      end
    end else if (div_en) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= rgb_t'(result);
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_red   = out_q.red;
  assign rsp_o.out_green = out_q.green;
  assign rsp_o.out_blue  = out_q.blue;

endmodule

`default_nettype wire

/* hw/rtl/palette_fade_interpolator.sv */
// Top level of the palette fade interpolator: configuration registers and the pipeline.
`default_nettype none

// Palette fade interpolator. Request words write an entry of the start or
// target palette, or read the faded colour of one entry at a given frame.
// A store write produces no response; writes stream at one word per cycle
// unless queued and in-flight reads would fill the read queue. In the front
// end a read's store lookup and classification are registered together,
// then the word is pushed into the queue. The back end loads and multiplies
// one read at a time, runs the divider steps of four quotient bits each,
// then makes the final select into the output register. The output register
// lets a new read start while a finished response waits. The palette
// stores have no reset and need no clearing pass; an entry must be written
// before it is read. Configuration registers may only be written while the
// block is idle.
module palette_fade_interpolator #(
  parameter int PaletteEntries = pfi_pkg::PaletteEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pfi_req_if.sink                       req_i,
  pfi_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfi_pkg::CfgAddrW-1:0]  paddr,
  input  logic [pfi_pkg::CfgDataW-1:0]  pwdata,
  output logic [pfi_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import pfi_pkg::*;

  cfg_t                   cfg_q;
  logic                   cfg_wr;
  cfg_reg_e               cfg_sel;
  logic                   q_push;
  work_t                  q_wdata;
  logic                   q_pop;
  logic                   q_valid;
  work_t                  q_rdata;
  logic [QueueLevelW-1:0] q_level;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[CfgAddrW-1:2]);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_count  <= FrameW'(30);
      cfg_q.first_index <= '0;
      cfg_q.last_index  <= '1;
      cfg_q.fade_mode   <= 1'b0;
      cfg_q.color_red   <= '0;
      cfg_q.color_green <= '0;
      cfg_q.color_blue  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_STEP_COUNT:  cfg_q.step_count  <= pwdata[FrameW-1:0];
        REG_FIRST_INDEX: cfg_q.first_index <= pwdata[IndexW-1:0];
        REG_LAST_INDEX:  cfg_q.last_index  <= pwdata[IndexW-1:0];
        REG_FADE_MODE:   cfg_q.fade_mode   <= pwdata[0];
        REG_COLOR_RED:   cfg_q.color_red   <= pwdata[Color6W-1:0];
        REG_COLOR_GREEN: cfg_q.color_green <= pwdata[Color6W-1:0];
        REG_COLOR_BLUE:  cfg_q.color_blue  <= pwdata[Color6W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_STEP_COUNT:  prdata = CfgDataW'(cfg_q.step_count);
      REG_FIRST_INDEX: prdata = CfgDataW'(cfg_q.first_index);
      REG_LAST_INDEX:  prdata = CfgDataW'(cfg_q.last_index);
      REG_FADE_MODE:   prdata = CfgDataW'(cfg_q.fade_mode);
      REG_COLOR_RED:   prdata = CfgDataW'(cfg_q.color_red);
      REG_COLOR_GREEN: prdata = CfgDataW'(cfg_q.color_green);
      REG_COLOR_BLUE:  prdata = CfgDataW'(cfg_q.color_blue);
      default: ;
    endcase
  end

  pfi_front #(
    .PaletteEntries (PaletteEntries)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .req_i     (req_i),
    .q_level_i (q_level),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  pfi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .level_o (q_level)
  );

  pfi_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench of the palette fade interpolator: directed and random traffic.

module testbench;
  import pfi_pkg::*;

  localparam logic [ReqW-1:0] ReqUnused = 2'd3;
  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 8;
  localparam int DrainCycles = 16;
  localparam int RandomItems = 2000;
  localparam int MaxShown    = 10;
  localparam int RunLimit    = 4_000_000;

  typedef struct packed {
    logic [ReqW-1:0]   kind;
    logic [IndexW-1:0] index;
    rgb_t              color;
    logic [FrameW-1:0] frame;
  } pal_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  pfi_req_if req_bus ();
  pfi_rsp_if rsp_bus ();

  // Shadow copy of both palettes and the registers
  rgb_t start_store  [PaletteEntries];
  rgb_t target_store [PaletteEntries];
  bit   start_known  [PaletteEntries];
  bit   target_known [PaletteEntries];
  cfg_t fade_cfg;

  rgb_t colors_due[$];
  int   mismatches = 0;
  int   reads_sent = 0;
  int   writes_sent = 0;
  int   colors_checked = 0;
  int   settings_used = 0;
  int   send_idle_pct = 0;
  int   take_idle_pct = 0;

  palette_fade_interpolator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Count a mismatch, show only the first few
  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Widen a 6-bit channel of the fixed color to 8 bits
  function automatic chan_t widen_6to8(logic [Color6W-1:0] c);
    return chan_t'((int'(c) * 255) / 63);
  endfunction

  // Step one channel from start toward target, dividing toward zero
  function automatic chan_t lerp_channel(chan_t from, chan_t to, logic [FrameW-1:0] frame,
                                         logic [FrameW-1:0] steps);
    int delta;
    int part;
    delta = int'(to) - int'(from);
    part  = (delta * int'(frame)) / int'(steps);
    return chan_t'(int'(from) + part);
  endfunction

  // Predict the faded color of one entry at one frame
  function automatic rgb_t faded_color(logic [IndexW-1:0] idx, logic [FrameW-1:0] frame);
    rgb_t from;
    rgb_t to;
    rgb_t res;
    from = start_store[idx];
    if (fade_cfg.fade_mode) begin
      to = target_store[idx];
    end else begin
      to.red   = widen_6to8(fade_cfg.color_red);
      to.green = widen_6to8(fade_cfg.color_green);
      to.blue  = widen_6to8(fade_cfg.color_blue);
    end
    if (frame >= fade_cfg.step_count) begin
      res = to;
    end else if (idx >= fade_cfg.first_index && idx <= fade_cfg.last_index) begin
      res.red   = lerp_channel(from.red, to.red, frame, fade_cfg.step_count);
      res.green = lerp_channel(from.green, to.green, frame, fade_cfg.step_count);
      res.blue  = lerp_channel(from.blue, to.blue, frame, fade_cfg.step_count);
    end else begin
      res = from;
    end
    return res;
  endfunction

  function automatic pal_req_t make_req(logic [ReqW-1:0] kind, logic [IndexW-1:0] idx,
                                        rgb_t color, logic [FrameW-1:0] frame);
    pal_req_t item;
    item.kind  = kind;
    item.index = idx;
    item.color = color;
    item.frame = frame;
    return item;
  endfunction

  // Drive one request word, wait for its handshake, update the shadow state
  task automatic send_request(input pal_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= item.kind;
    req_bus.entry_index  <= item.index;
    req_bus.in_red       <= item.color.red;
    req_bus.in_green     <= item.color.green;
    req_bus.in_blue      <= item.color.blue;
    req_bus.frame_number <= item.frame;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    case (item.kind)
      REQ_WR_START: begin
        start_store[item.index] = item.color;
        start_known[item.index] = 1'b1;
        writes_sent++;
      end
      REQ_WR_TARGET: begin
        target_store[item.index] = item.color;
        target_known[item.index] = 1'b1;
        writes_sent++;
      end
      REQ_RD_FADED: begin
        colors_due.push_back(faded_color(item.index, item.frame));
        reads_sent++;
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Hold requests until every predicted color has come back
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(negedge clk_i); while (colors_due.size() != 0);
  endtask

  // One APB transfer: setup cycle, access cycle, then an idle cycle
  task automatic apb_access(input cfg_reg_e which, input logic wr,
                            input logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CfgAddrW'(int'(which) * 4);
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_register(input cfg_reg_e which, input int value);
    logic [CfgDataW-1:0] back;
    apb_access(which, 1'b0, '0, back);
    if (back !== CfgDataW'(value)) begin
      note_mismatch($sformatf("register %s", which.name()), CfgDataW'(value), back);
    end
  endtask

  task automatic set_register(input cfg_reg_e which, input int value);
    logic [CfgDataW-1:0] unused_data;
    apb_access(which, 1'b1, CfgDataW'(value), unused_data);
    case (which)
      REG_STEP_COUNT:  fade_cfg.step_count  = FrameW'(value);
      REG_FIRST_INDEX: fade_cfg.first_index = IndexW'(value);
      REG_LAST_INDEX:  fade_cfg.last_index  = IndexW'(value);
      REG_FADE_MODE:   fade_cfg.fade_mode   = value[0];
      REG_COLOR_RED:   fade_cfg.color_red   = Color6W'(value);
      REG_COLOR_GREEN: fade_cfg.color_green = Color6W'(value);
      REG_COLOR_BLUE:  fade_cfg.color_blue  = Color6W'(value);
      default: ;
    endcase
    check_register(which, value);
  endtask

  // Let the block go idle, then rewrite every register
  task automatic apply_setting(input int steps, input int first, input int last,
                               input int mode, input int red, input int green,
                               input int blue);
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    set_register(REG_STEP_COUNT, steps);
    set_register(REG_FIRST_INDEX, first);
    set_register(REG_LAST_INDEX, last);
    set_register(REG_FADE_MODE, mode);
    set_register(REG_COLOR_RED, red);
    set_register(REG_COLOR_GREEN, green);
    set_register(REG_COLOR_BLUE, blue);
    settings_used++;
  endtask

  function automatic int pick_color6();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 63;
      default: return $urandom_range(63);
    endcase
  endfunction

  task automatic random_setting();
    int steps;
    int lo;
    int hi;
    case ($urandom_range(4))
      0:       steps = 0;
      1:       steps = 1;
      2:       steps = 255;
      default: steps = $urandom_range(64, 2);
    endcase
    case ($urandom_range(3))
      0: begin
        lo = 0;
        hi = 255;
      end
      1: begin
        lo = $urandom_range(255);
        hi = lo;
      end
      2: begin
        // May come out empty
        lo = $urandom_range(255);
        hi = $urandom_range(255);
      end
      default: begin
        lo = $urandom_range(127);
        hi = $urandom_range(255, 128);
      end
    endcase
    apply_setting(steps, lo, hi, $urandom_range(1), pick_color6(), pick_color6(),
                  pick_color6());
  endtask

  // Build a random request; a read of an unwritten entry becomes a write of it
  function automatic pal_req_t random_request();
    pal_req_t item;
    int       pick;
    case ($urandom_range(9))
      0:       item.index = fade_cfg.first_index;
      1:       item.index = fade_cfg.last_index;
      2:       item.index = fade_cfg.first_index - 8'd1;
      3:       item.index = fade_cfg.last_index + 8'd1;
      default: item.index = IndexW'($urandom_range(PaletteEntries - 1));
    endcase
    case ($urandom_range(9))
      0:       item.frame = fade_cfg.step_count;
      1:       item.frame = fade_cfg.step_count - 8'd1;
      2, 3:    item.frame = FrameW'($urandom_range(255));
      default: item.frame = FrameW'($urandom_range(fade_cfg.step_count));
    endcase
    item.color = rgb_t'(24'($urandom));
    pick = $urandom_range(99);
    if (pick < 4) begin
      item.kind = ReqUnused;
    end else if (pick < 28) begin
      item.kind = REQ_WR_START;
    end else if (pick < 46) begin
      item.kind = REQ_WR_TARGET;
    end else begin
      item.kind = REQ_RD_FADED;
    end
    if (item.kind == REQ_RD_FADED && !start_known[item.index]) begin
      item.kind = REQ_WR_START;
    end else if (item.kind == REQ_RD_FADED && fade_cfg.fade_mode &&
                 !target_known[item.index]) begin
      item.kind = REQ_WR_TARGET;
    end
    return item;
  endfunction

  // Send random requests; ignored codes do not count
  task automatic send_random(input int count);
    pal_req_t item;
    int       done;
    done = 0;
    while (done < count) begin
      item = random_request();
      send_request(item);
      if (item.kind != ReqUnused) begin
        done++;
      end
    end
  endtask

  task automatic test_register_defaults();
    check_register(REG_STEP_COUNT, 30);
    check_register(REG_FIRST_INDEX, 0);
    check_register(REG_LAST_INDEX, 255);
    check_register(REG_FADE_MODE, 0);
    check_register(REG_COLOR_RED, 0);
    check_register(REG_COLOR_GREEN, 0);
    check_register(REG_COLOR_BLUE, 0);
  endtask

  // Fade toward black, then toward a fixed color, from extreme and middle start entries
  task automatic test_fixed_color_fade();
    send_request(make_req(REQ_WR_START, 8'd0, 24'h000000, 8'd0));
    send_request(make_req(REQ_WR_START, 8'd255, 24'hFFFFFF, 8'd255));
    send_request(make_req(REQ_WR_START, 8'd128, 24'h5AA53C, 8'd0));
    send_request(make_req(ReqUnused, 8'd0, 24'hFFFFFF, 8'd0));
    send_request(make_req(REQ_RD_FADED, 8'd0, '0, 8'd0));
    send_request(make_req(REQ_RD_FADED, 8'd255, '0, 8'd0));
    send_request(make_req(REQ_RD_FADED, 8'd255, '0, 8'd15));
    send_request(make_req(REQ_RD_FADED, 8'd255, '0, 8'd29));
    send_request(make_req(REQ_RD_FADED, 8'd128, '0, 8'd30));
    send_request(make_req(REQ_RD_FADED, 8'd0, '0, 8'd255));
    apply_setting(30, 0, 255, 0, 63, 0, 42);
    send_request(make_req(REQ_RD_FADED, 8'd0, '0, 8'd10));
    send_request(make_req(REQ_RD_FADED, 8'd128, '0, 8'd29));
  endtask

  // Fade toward the target store with the largest step count
  task automatic test_target_palette_fade();
    apply_setting(255, 0, 255, 1, 0, 0, 0);
    send_request(make_req(REQ_WR_TARGET, 8'd0, 24'hFFFFFF, 8'd0));
    send_request(make_req(REQ_WR_TARGET, 8'd255, 24'h000000, 8'd0));
    send_request(make_req(REQ_WR_TARGET, 8'd128, 24'h1EC8FF, 8'd0));
    send_request(make_req(REQ_RD_FADED, 8'd0, '0, 8'd254));
    send_request(make_req(REQ_RD_FADED, 8'd255, '0, 8'd128));
    send_request(make_req(REQ_RD_FADED, 8'd128, '0, 8'd1));
    send_request(make_req(REQ_RD_FADED, 8'd128, '0, 8'd255));
  endtask

  // Zero steps, an empty range and a single-entry range
  task automatic test_range_and_step_edges();
    apply_setting(0, 0, 255, 1, 0, 0, 0);
    send_request(make_req(REQ_RD_FADED, 8'd128, '0, 8'd0));
    apply_setting(30, 200, 100, 1, 0, 0, 0);
    send_request(make_req(REQ_RD_FADED, 8'd128, '0, 8'd10));
    send_request(make_req(REQ_RD_FADED, 8'd0, '0, 8'd30));
    apply_setting(30, 255, 255, 1, 0, 0, 0);
    send_request(make_req(REQ_RD_FADED, 8'd255, '0, 8'd10));
    send_request(make_req(REQ_RD_FADED, 8'd128, '0, 8'd10));
  endtask

  // Random traffic over three register settings at one idling pattern
  task automatic test_random_traffic(input int send_pct, input int take_pct, input int count);
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    for (int round = 0; round < 3; round++) begin
      random_setting();
      if (round == 1) begin
        send_random(count / 6);
        wait_drained();
        send_random(count / 6);
      end else begin
        send_random(count / 3);
      end
    end
  endtask

  // Stall the response side at random
  always @(negedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Compare each accepted color word with the oldest prediction
  always @(posedge clk_i) begin : check_colors
    rgb_t want;
    rgb_t got;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got.red   = rsp_bus.out_red;
      got.green = rsp_bus.out_green;
      got.blue  = rsp_bus.out_blue;
      if (colors_due.size() == 0) begin
        note_mismatch("color word with no read pending", '0, {8'h00, got});
      end else begin
        want = colors_due.pop_front();
        colors_checked++;
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          note_mismatch("faded color {blue,green,red}", {8'h00, want}, {8'h00, got});
        end
      end
    end
  end

  initial begin
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = '0;
    req_bus.entry_index  = '0;
    req_bus.in_red       = '0;
    req_bus.in_green     = '0;
    req_bus.in_blue      = '0;
    req_bus.frame_number = '0;
    rsp_bus.ready        = 1'b0;
    fade_cfg = '{step_count: 8'd30, first_index: 8'd0, last_index: 8'd255,
                 fade_mode: 1'b0, color_red: '0, color_green: '0, color_blue: '0};

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_register_defaults();
    test_fixed_color_fade();
    test_target_palette_fade();
    test_range_and_step_edges();
    test_random_traffic(35, 83, RandomItems / 3);
    test_random_traffic(83, 35, RandomItems / 3);
    test_random_traffic(0, 0, RandomItems / 3);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    $display("Run: %0d palette writes and %0d faded reads under %0d register settings,",
             writes_sent, reads_sent, settings_used);
    $display("     %0d colors compared, %0d mismatches.", colors_checked, mismatches);
    if (mismatches == 0 && colors_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #RunLimit;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
